/* design/assert_macros.svh */
// Assertion helpers shared by the sorter RTL.
// Every check is clocked on clk and switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside reset.
`define CRS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never becomes true.
`define CRS_ASSERT_NEVER(label, cond, msg) \
	`CRS_ASSERT(label, !(cond), msg)

`endif

/* design/crs_pkg.sv */
package crs_pkg;

	localparam int MAX_RULES  = 64;
	localparam int SPEC_WIDTH = 16;

	localparam int IDX_W     = 6;
	localparam int ORD_W     = 6;
	localparam int SPEC_IN_W = 16;
	localparam int CNT_W     = $clog2(MAX_RULES + 1);

	typedef struct packed {
		logic [IDX_W-1:0]      idx;
		logic [SPEC_WIDTH-1:0] spec;
		logic [ORD_W-1:0]      ord;
	} crs_entry_t;

	// Operation broadcast to every cell in the chain.
	typedef struct packed {
		logic insert;
		logic pop;
	} crs_ctrl_t;

endpackage

/* design/crs_cell.sv */
module crs_cell (
	input  logic               clk,
	input  crs_pkg::crs_ctrl_t  ctrl,
	input  crs_pkg::crs_entry_t new_entry,
	input  crs_pkg::crs_entry_t prev_entry,
	input  crs_pkg::crs_entry_t next_entry,
	input  logic               prev_moves,
	input  logic               prev_valid,
	input  logic               own_valid,
	output crs_pkg::crs_entry_t entry,
	output logic               moves
);
	import crs_pkg::*;

	crs_entry_t entry_q;

	// The held rule must step aside when it sorts strictly after the new one.
	assign moves = own_valid && ((entry_q.spec > new_entry.spec) ||
		((entry_q.spec == new_entry.spec) && (entry_q.ord > new_entry.ord)));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			entry_q <= next_entry;
		end else if (ctrl.insert) begin
			if (prev_moves) begin
				entry_q <= prev_entry;
			end else if (moves || (!own_valid && prev_valid)) begin
				entry_q <= new_entry;
			end
		end
	end

endmodule

/* design/cascade_rule_order_sorter_core.sv */
// Channel | Handshake          | Word
// in      | in_valid, in_ready | rule_index, specificity, doc_order, matched, last_rule
// out     | out_valid, out_ready | out_index, out_last
//
// While a sheet is being collected one rule word is taken every cycle.
// A word with last_rule set starts the drain when the row then holds at least one rule:
// one index leaves per cycle while out_ready is high, shifted out of the cell row.
// The input is held off only during the drain; the final index may still wait in the
// output register while the next sheet starts.
// Reset (arst_n low) empties the row and the output register; no clearing pass is needed.
module cascade_rule_order_sorter_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [crs_pkg::IDX_W-1:0]        rule_index,
	input  logic [crs_pkg::SPEC_IN_W-1:0]    specificity,
	input  logic [crs_pkg::ORD_W-1:0]        doc_order,
	input  logic                             matched,
	input  logic                             last_rule,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [crs_pkg::IDX_W-1:0]        out_index,
	output logic                             out_last
);
	import crs_pkg::*;

	`include "assert_macros.svh"

	// Number of kept rules; cells below this count hold valid entries, in sorted order.
	logic [CNT_W-1:0]   entry_count_q;
	// High while the row is being shifted out towards the output register.
	logic               draining_q;
	logic               out_valid_q;
	logic [IDX_W-1:0]   out_index_q;
	logic               out_last_q;

	logic               accept;
	logic               full;
	logic               pop;
	logic               final_pop;
	crs_ctrl_t          ctrl;
	crs_entry_t         new_entry;
	crs_entry_t         cell_data  [MAX_RULES];
	logic [MAX_RULES-1:0] cell_moves;
	logic [MAX_RULES-1:0] cell_valid;

	assign in_ready  = !draining_q;
	assign accept    = in_valid && in_ready;
	assign full      = (entry_count_q == CNT_W'(MAX_RULES));
	assign pop       = draining_q && (!out_valid_q || out_ready);
	assign final_pop = pop && (entry_count_q == CNT_W'(1));

	// A matched rule is dropped silently when the row is already full.
	assign ctrl.insert = accept && matched && !full;
	assign ctrl.pop    = pop;

	// Only the low SPEC_WIDTH bits of the specificity take part in the ordering.
	assign new_entry.idx  = rule_index;
	assign new_entry.spec = SPEC_WIDTH'(specificity);
	assign new_entry.ord  = doc_order;

	// Each cell inserts the new rule, takes its left neighbour's rule when that one steps
	// right, or takes its right neighbour's rule while the row drains towards cell zero.
	for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
		crs_entry_t prev_entry;
		crs_entry_t next_entry;
		logic       prev_moves;
		logic       prev_valid;

		assign cell_valid[i] = (entry_count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign prev_entry = '0;
			assign prev_moves = 1'b0;
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_entry = cell_data[i-1];
			assign prev_moves = cell_moves[i-1];
			assign prev_valid = cell_valid[i-1];
		end

		if (i == MAX_RULES - 1) begin : g_tail
			assign next_entry = '0;
		end else begin : g_link
			assign next_entry = cell_data[i+1];
		end

		crs_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.prev_moves (prev_moves),
			.prev_valid (prev_valid),
			.own_valid  (cell_valid[i]),
			.entry      (cell_data[i]),
			.moves      (cell_moves[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			draining_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (ctrl.insert) begin
				entry_count_q <= entry_count_q + CNT_W'(1);
			end else if (pop) begin
				entry_count_q <= entry_count_q - CNT_W'(1);
			end

			// The drain starts only when the row holds at least one rule after this word.
			if (accept && last_rule && ((entry_count_q != '0) || matched)) begin
				draining_q <= 1'b1;
			end else if (final_pop) begin
				draining_q <= 1'b0;
			end

			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_index_q <= cell_data[0].idx;
			out_last_q  <= (entry_count_q == CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_last  = out_last_q;

	`CRS_ASSERT_NEVER(a_count_range, entry_count_q > CNT_W'(MAX_RULES), "entry count beyond capacity")
	`CRS_ASSERT_NEVER(a_drain_nonempty, draining_q && (entry_count_q == '0), "drain with empty row")
	`CRS_ASSERT(a_final_pop_ends, final_pop |=> (!draining_q && out_valid && out_last), "drain did not end on last index")
	`CRS_ASSERT(a_last_match_drains, (accept && last_rule && matched) |=> draining_q, "matched last rule did not start drain")

endmodule
